### src/annexb_nal_codec_sniffer_core_assert.svh
// ---------------------------------------------------------------------------
// annexb_nal_codec_sniffer_core_assert.svh
// assertion macros shared by the checker of the codec sniffer
// ---------------------------------------------------------------------------
`ifndef ANNEXB_NAL_CODEC_SNIFFER_CORE_ASSERT_SVH
`define ANNEXB_NAL_CODEC_SNIFFER_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define ANB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sniffer check failed");

// next-cycle implication, disabled while reset is asserted
`define ANB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sniffer check failed");

`endif

### src/anb_pkg.sv
// ---------------------------------------------------------------------------
// anb_pkg
// types, codes and helper functions of the annex b codec sniffer
// ---------------------------------------------------------------------------
package anb_pkg;

  // scan phases of the start-code parser
  typedef enum logic [1:0] {
    PH_SCAN = 2'd0,
    PH_HDR0 = 2'd1,
    PH_HDR1 = 2'd2,
    PH_SKIP = 2'd3
  } phase_e;

  // codec codes on the result stream
  typedef enum logic [1:0] {
    CODE_UNKNOWN = 2'd0,
    CODE_AVC     = 2'd1,
    CODE_HEVC    = 2'd2,
    CODE_VVC     = 2'd3
  } codec_e;

  localparam logic [7:0] MaxUnitsReset = 8'd50;

  // one input byte with its end-of-stream mark
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } anb_item_t;

  // decision made for one byte
  typedef struct packed {
    logic   emit;
    codec_e code;
  } anb_result_t;

  // avc profile ids that identify an avc sps
  function automatic logic listed_profile(input logic [7:0] p);
    logic hit;
    case (p)
      8'd44, 8'd66, 8'd77, 8'd83, 8'd86, 8'd88, 8'd100, 8'd110,
      8'd118, 8'd122, 8'd128, 8'd134, 8'd135, 8'd138, 8'd139,
      8'd244: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  // hevc vps/sps/pps nal types
  function automatic logic hevc_type(input logic [7:0] b0);
    logic [5:0] t;
    t = b0[6:1];
    return (t >= 6'd32) && (t <= 6'd34);
  endfunction

endpackage

### src/anb_in_stage.sv
// ---------------------------------------------------------------------------
// anb_in_stage
// input register of the sniffer, advances whenever the result slot is free
// ---------------------------------------------------------------------------
module anb_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_valid_i,
  output logic               s_ready_o,
  input  anb_pkg::anb_item_t s_item_i,
  input  logic               out_free_i,
  output logic               fire_o,
  output anb_pkg::anb_item_t item_o
);
  import anb_pkg::*;

  logic      valid_q;
  anb_item_t item_q;

  // held word is consumed when the result register can take a word
  assign fire_o    = valid_q && out_free_i;
  assign s_ready_o = !valid_q || fire_o;
  assign item_o    = item_q;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_ready_o) begin
      valid_q <= s_valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (s_valid_i && s_ready_o) begin
      item_q <= s_item_i;
    end
  end

endmodule

### src/anb_sniff.sv
// ---------------------------------------------------------------------------
// anb_sniff
// start-code parser state, nal header checks and the unit limit register
// ---------------------------------------------------------------------------
module anb_sniff (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  anb_pkg::anb_item_t   item_i,
  input  logic                 cfg_we_i,
  input  logic [7:0]           cfg_wdata_i,
  output anb_pkg::anb_result_t result_o
);
  import anb_pkg::*;

  phase_e     phase_q, phase_d, phase_raw;
  logic [1:0] zero_run_q, zero_run_d;
  logic [7:0] hdr0_q, hdr0_d;
  logic [7:0] unit_cnt_q, unit_cnt_d;
  logic [7:0] max_units_q;

  logic [7:0] b;
  logic       last;
  logic       start_code, limit_at_sc, limit_next;
  logic       is_avc, is_hevc, is_vvc, hit;
  logic [7:0] cnt_inc;
  logic       emit_core;
  codec_e     code;

  assign b    = item_i.data_byte;
  assign last = item_i.last_byte;

  // start code and header checks
  assign start_code  = (b == 8'd1) && zero_run_q[1];
  assign limit_at_sc = unit_cnt_q >= max_units_q;
  assign is_avc      = (hdr0_q[4:0] == 5'd7) && listed_profile(b);
  assign is_hevc     = hevc_type(hdr0_q) && !hdr0_q[0] && (b[7:3] == 5'd0) &&
                       (b[2:0] != 3'd0);
  assign is_vvc      = (b[7:3] >= 5'd14) && (b[7:3] <= 5'd16);
  assign hit         = is_avc || is_hevc || is_vvc;
  assign cnt_inc     = (unit_cnt_q == 8'hFF) ? unit_cnt_q : unit_cnt_q + 8'd1;
  assign limit_next  = cnt_inc >= max_units_q;

  // next phase
  always_comb begin
    phase_raw = phase_q;
    case (phase_q)
      PH_SCAN: begin
        if (start_code) begin
          phase_raw = limit_at_sc ? PH_SKIP : PH_HDR0;
        end
      end
      PH_HDR0: begin
        phase_raw = last ? PH_HDR0 : PH_HDR1;
      end
      PH_HDR1: begin
        phase_raw = (hit || limit_next) ? PH_SKIP : PH_SCAN;
      end
      PH_SKIP: begin
        phase_raw = PH_SKIP;
      end
      default: begin
        phase_raw = PH_SCAN;
      end
    endcase
    phase_d = last ? PH_SCAN : phase_raw;
  end

  // decision outputs
  always_comb begin
    emit_core = 1'b0;
    code      = CODE_UNKNOWN;
    case (phase_q)
      PH_SCAN: begin
        emit_core = start_code && limit_at_sc;
      end
      PH_HDR0: begin
        emit_core = last;
        if (hevc_type(b)) begin
          code = CODE_HEVC;
        end
      end
      PH_HDR1: begin
        emit_core = hit || limit_next;
        if (is_avc) begin
          code = CODE_AVC;
        end else if (is_hevc) begin
          code = CODE_HEVC;
        end else if (is_vvc) begin
          code = CODE_VVC;
        end
      end
      default: begin
        emit_core = 1'b0;
      end
    endcase
    // end of stream without a decision reports unknown, but hevc on an hevc first header byte
    result_o.emit = emit_core || (last && (phase_q != PH_SKIP));
    result_o.code = emit_core ? code : CODE_UNKNOWN;
  end

  // zero run, header byte and unit count
  always_comb begin
    zero_run_d = zero_run_q;
    hdr0_d     = hdr0_q;
    unit_cnt_d = unit_cnt_q;
    case (phase_q)
      PH_SCAN: begin
        if (b == 8'd0) begin
          zero_run_d = zero_run_q[1] ? zero_run_q : zero_run_q + 2'd1;
        end else begin
          zero_run_d = 2'd0;
        end
      end
      PH_HDR0: begin
        hdr0_d = b;
      end
      PH_HDR1: begin
        if (!hit) begin
          unit_cnt_d = cnt_inc;
          if (!limit_next) begin
            zero_run_d = (b == 8'd0) ? 2'd1 : 2'd0;
          end
        end
      end
      default: begin
        zero_run_d = zero_run_q;
      end
    endcase
    if (last) begin
      zero_run_d = 2'd0;
      hdr0_d     = 8'd0;
      unit_cnt_d = 8'd0;
    end
  end

  // stream state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_SCAN;
      zero_run_q <= 2'd0;
      hdr0_q     <= 8'd0;
      unit_cnt_q <= 8'd0;
    end else if (fire_i) begin
      phase_q    <= phase_d;
      zero_run_q <= zero_run_d;
      hdr0_q     <= hdr0_d;
      unit_cnt_q <= unit_cnt_d;
    end
  end

  // unit limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_units_q <= MaxUnitsReset;
    end else if (cfg_we_i) begin
      max_units_q <= cfg_wdata_i;
    end
  end

endmodule

### src/anb_out_reg.sv
// ---------------------------------------------------------------------------
// anb_out_reg
// result register holding one codec code until the sink takes it
// ---------------------------------------------------------------------------
module anb_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  anb_pkg::anb_result_t result_i,
  output logic                 free_o,
  output logic                 m_valid_o,
  input  logic                 m_ready_i,
  output anb_pkg::codec_e      code_o
);
  import anb_pkg::*;

  logic   valid_q;
  codec_e code_q;

  assign free_o    = !valid_q || m_ready_i;
  assign m_valid_o = valid_q;
  assign code_o    = code_q;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (fire_i && result_i.emit) begin
      valid_q <= 1'b1;
    end else if (m_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // code payload
  always_ff @(posedge clk_i) begin
    if (fire_i && result_i.emit) begin
      code_q <= result_i.code;
    end
  end

endmodule

### src/annexb_nal_codec_sniffer_core.sv
// ---------------------------------------------------------------------------
// annexb_nal_codec_sniffer_core
// annex b start-code sniffer reporting the video codec of each stream
// ---------------------------------------------------------------------------
// Takes one stream byte per cycle, sustained while the sink takes codes, with
// tlast on the final byte. A byte is held in the input register and is
// decided on its way into the result register, so a code is registered on the
// result stream as the byte that caused it leaves the input register; one
// code is produced per stream (0 unknown, 1 avc, 2 hevc, 3 vvc). While the
// sink holds off a waiting code the input register cannot move on, so the
// input takes at most one more byte and then stalls until the code is taken.
// cfg_we_i writes the unit limit (reset 50); write it only while the block is
// idle.
module annexb_nal_codec_sniffer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  // unit limit register
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  // byte stream
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tlast,   // last_byte
  // codec codes
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [1:0] codec_code, [7:2] zero
);
  import anb_pkg::*;

  anb_item_t   s_item, item;
  anb_result_t result;
  logic        fire, out_free;
  codec_e      code;

  assign s_item.data_byte = s_axis_tdata;
  assign s_item.last_byte = s_axis_tlast;

  // input register
  anb_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_o  (s_axis_tready),
    .s_item_i   (s_item),
    .out_free_i (out_free),
    .fire_o     (fire),
    .item_o     (item)
  );

  // parser and decision
  anb_sniff u_sniff (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .item_i      (item),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .result_o    (result)
  );

  // result register
  anb_out_reg u_out_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .result_i  (result),
    .free_o    (out_free),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .code_o    (code)
  );

  assign m_axis_tdata = {6'd0, code};

endmodule

### src/anb_sniff_checker.sv
// ---------------------------------------------------------------------------
// anb_sniff_checker
// port-level checks of the codec sniffer, bound to the top level
// ---------------------------------------------------------------------------
`include "annexb_nal_codec_sniffer_core_assert.svh"

module anb_sniff_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  // a stalled code stays put
  `ANB_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `ANB_ASSERT_NXT(a_out_stable, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
  // input never stalls while the result slot is free
  `ANB_ASSERT_IMP(a_in_ready, clk_i, rst_ni, !m_axis_tvalid || m_axis_tready, s_axis_tready)
  // code padding is zero
  `ANB_ASSERT_IMP(a_pad_zero, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[7:2] == 6'd0)

endmodule

bind annexb_nal_codec_sniffer_core anb_sniff_checker u_anb_sniff_checker (.*);
